// ----- rtl/cpf_pkg.sv -----
// Shared types and constants for the photo stream framer.
package cpf_pkg;

  localparam int unsigned CHUNK_DEF   = 246;  // photo bytes per data frame
  localparam int unsigned QUEUE_DEPTH = 4;    // command queue entries, power of two

  localparam logic [7:0] SYNC_A        = 8'hEF;
  localparam logic [7:0] SYNC_B        = 8'hAA;
  localparam logic [7:0] TYPE_NORMAL   = 8'h00;
  localparam logic [7:0] FIRST_LEN_HI  = 8'h00;
  localparam logic [7:0] FIRST_LEN_LO  = 8'h07;
  localparam logic [7:0] ID_RESET      = 8'hF7;

  // byte positions inside a frame
  localparam logic [3:0] STEP_FIRST_BYTE  = 4'd0;
  localparam logic [3:0] STEP_PAYLOAD     = 4'd7;
  localparam logic [3:0] STEP_CHECK_DATA  = 4'd8;
  localparam logic [3:0] STEP_CHECK_FIRST = 4'd12;

  typedef enum logic {
    REG_PHOTO_LEN = 1'b0,
    REG_MSG_ID    = 1'b1
  } reg_idx_e;

  typedef enum logic {
    MODE_START = 1'b0,
    MODE_BYTE  = 1'b1
  } mode_e;

  typedef enum logic {
    CMD_FIRST = 1'b0,
    CMD_DATA  = 1'b1
  } cmd_kind_e;

  // one queued frame fragment, fully resolved by the front end
  typedef struct packed {
    cmd_kind_e   kind;
    logic        hdr;        // data: open a new frame first
    logic        close;      // data: append check byte
    logic [7:0]  msg_id;
    logic [7:0]  len_lo;     // data frame payload length, high byte is zero
    logic [15:0] seq;
    logic [7:0]  pbyte;
    logic [7:0]  check;
    logic [31:0] photo_len;
  } cmd_t;

endpackage

// ----- rtl/cpf_front.sv -----
// Front end: accepts input items, tracks frame counters, issues commands.
module cpf_front #(
  parameter int unsigned Chunk = cpf_pkg::CHUNK_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              in_mode_i,
  input  logic [7:0]        in_byte_i,
  input  logic [31:0]       photo_len_i,
  input  logic [7:0]        msg_id_i,
  output logic              cmd_valid_o,
  input  logic              cmd_ready_i,
  output cpf_pkg::cmd_t     cmd_o
);
  import cpf_pkg::*;

  logic [31:0] bytes_left_q, bytes_left_d;
  logic [7:0]  chunk_left_q, chunk_left_d;
  logic [15:0] seq_q, seq_d;
  logic [7:0]  acc_q, acc_d;

  logic        accept;
  logic        hdr;
  logic [7:0]  n, len_lo, cl, cl_new, acc_base, acc_new, first_chk;

  assign in_ready_o = cmd_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    hdr       = (chunk_left_q == 8'd0);
    n         = (bytes_left_q < 32'(Chunk)) ? bytes_left_q[7:0] : 8'(Chunk);
    len_lo    = n + 8'd2;
    cl        = hdr ? n : chunk_left_q;
    cl_new    = cl - 8'd1;
    acc_base  = hdr ? (msg_id_i ^ len_lo ^ seq_q[15:8] ^ seq_q[7:0]) : acc_q;
    acc_new   = acc_base ^ in_byte_i;
    first_chk = msg_id_i ^ FIRST_LEN_HI ^ FIRST_LEN_LO ^ photo_len_i[31:24]
              ^ photo_len_i[23:16] ^ photo_len_i[15:8] ^ photo_len_i[7:0];

    bytes_left_d = bytes_left_q;
    chunk_left_d = chunk_left_q;
    seq_d        = seq_q;
    acc_d        = acc_q;
    cmd_valid_o  = 1'b0;

    cmd_o.kind      = CMD_DATA;
    cmd_o.hdr       = hdr;
    cmd_o.close     = (cl_new == 8'd0);
    cmd_o.msg_id    = msg_id_i;
    cmd_o.len_lo    = len_lo;
    cmd_o.seq       = seq_q;
    cmd_o.pbyte     = in_byte_i;
    cmd_o.check     = acc_new;
    cmd_o.photo_len = photo_len_i;

    if (in_mode_i == MODE_START) begin
      cmd_o.kind   = CMD_FIRST;
      cmd_o.check  = first_chk;
      cmd_valid_o  = in_valid_i;
      if (accept) begin
        bytes_left_d = photo_len_i;
        chunk_left_d = 8'd0;
        seq_d        = 16'd1;
        acc_d        = 8'd0;
      end
    end else if (bytes_left_q != 32'd0) begin
      cmd_valid_o = in_valid_i;
      if (accept) begin
        bytes_left_d = bytes_left_q - 32'd1;
        chunk_left_d = cl_new;
        if (cl_new == 8'd0) begin
          seq_d = seq_q + 16'd1;
          acc_d = 8'd0;
        end else begin
          acc_d = acc_new;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bytes_left_q <= '0;
      chunk_left_q <= '0;
      seq_q        <= 16'd1;
      acc_q        <= '0;
    end else begin
      bytes_left_q <= bytes_left_d;
      chunk_left_q <= chunk_left_d;
      seq_q        <= seq_d;
      acc_q        <= acc_d;
    end
  end

endmodule

// ----- rtl/cpf_cmd_fifo.sv -----
// Small command queue between front end and byte emitter.
module cpf_cmd_fifo #(
  parameter int unsigned Depth = cpf_pkg::QUEUE_DEPTH
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          wr_valid_i,
  output logic          wr_ready_o,
  input  cpf_pkg::cmd_t wr_data_i,
  output logic          rd_valid_o,
  input  logic          rd_pop_i,
  output cpf_pkg::cmd_t rd_data_o
);
  import cpf_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  cmd_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic            push, pop;

  assign wr_ready_o = (count_q != CntW'(Depth));
  assign rd_valid_o = (count_q != '0);
  assign push       = wr_valid_i && wr_ready_o;
  assign pop        = rd_pop_i && rd_valid_o;
  assign rd_data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) wr_ptr_q <= wr_ptr_q + PtrW'(1);
      if (pop)  rd_ptr_q <= rd_ptr_q + PtrW'(1);
      count_q <= count_q + CntW'(push) - CntW'(pop);
    end
  end

endmodule

// ----- rtl/cpf_back.sv -----
// Back end: expands queued commands into framed bytes, one per cycle unless stalled.
module cpf_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cmd_valid_i,
  input  cpf_pkg::cmd_t cmd_i,
  output logic          cmd_pop_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output logic [7:0]    out_byte_o,
  output logic          frame_end_o,
  output logic          run_last_o
);
  import cpf_pkg::*;

  logic       first_q, first_d;
  logic [3:0] step_q, step_d, step_cur, step_last;
  logic       load;
  logic [7:0] byte_sel;
  logic       valid_q, end_q, last_q;
  logic [7:0] byte_q;

  assign load = cmd_valid_i && (!valid_q || out_ready_i);

  always_comb begin
    if (first_q) begin
      step_cur = (cmd_i.kind == CMD_DATA && !cmd_i.hdr) ? STEP_PAYLOAD : STEP_FIRST_BYTE;
    end else begin
      step_cur = step_q;
    end
    if (cmd_i.kind == CMD_FIRST) begin
      step_last = STEP_CHECK_FIRST;
    end else begin
      step_last = cmd_i.close ? STEP_CHECK_DATA : STEP_PAYLOAD;
    end

    byte_sel = 8'h00;
    if (cmd_i.kind == CMD_FIRST) begin
      case (step_cur)
        4'd0:    byte_sel = SYNC_A;
        4'd1:    byte_sel = SYNC_B;
        4'd2:    byte_sel = cmd_i.msg_id;
        4'd3:    byte_sel = FIRST_LEN_HI;
        4'd4:    byte_sel = FIRST_LEN_LO;
        4'd7:    byte_sel = cmd_i.photo_len[31:24];
        4'd8:    byte_sel = cmd_i.photo_len[23:16];
        4'd9:    byte_sel = cmd_i.photo_len[15:8];
        4'd10:   byte_sel = cmd_i.photo_len[7:0];
        4'd11:   byte_sel = TYPE_NORMAL;
        4'd12:   byte_sel = cmd_i.check;
        default: byte_sel = 8'h00;  // two zero bytes opening the payload
      endcase
    end else begin
      case (step_cur)
        4'd0:    byte_sel = SYNC_A;
        4'd1:    byte_sel = SYNC_B;
        4'd2:    byte_sel = cmd_i.msg_id;
        4'd3:    byte_sel = 8'h00;
        4'd4:    byte_sel = cmd_i.len_lo;
        4'd5:    byte_sel = cmd_i.seq[15:8];
        4'd6:    byte_sel = cmd_i.seq[7:0];
        4'd7:    byte_sel = cmd_i.pbyte;
        4'd8:    byte_sel = cmd_i.check;
        default: byte_sel = 8'h00;
      endcase
    end

    cmd_pop_o = load && (step_cur == step_last);
    first_d   = first_q;
    step_d    = step_q;
    if (load) begin
      first_d = cmd_pop_o;
      step_d  = step_cur + 4'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_q <= 1'b1;
      step_q  <= '0;
      valid_q <= 1'b0;
    end else begin
      first_q <= first_d;
      step_q  <= step_d;
      if (load) begin
        valid_q <= 1'b1;
      end else if (out_ready_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_q <= byte_sel;
      end_q  <= (cmd_i.kind == CMD_FIRST) ? (step_cur == STEP_CHECK_FIRST)
                                          : (step_cur == STEP_CHECK_DATA);
      last_q <= (step_cur == step_last);
    end
  end

  assign out_valid_o = valid_q;
  assign out_byte_o  = byte_q;
  assign frame_end_o = end_q;
  assign run_last_o  = last_q;

endmodule

// ----- rtl/chunked_photo_framer_top.sv -----
// Top level of the photo stream framer.
//
// Input stream (s_axis_*): one transfer per item. tuser[0] is the mode,
// 0 = start (emit the 13-byte first frame, restart counters), 1 = photo byte
// carried in tdata[7:0]. Photo bytes beyond the programmed length, or before
// any start, are taken and dropped with no output.
// Output stream (m_axis_*): one framed serial byte per transfer in tdata,
// tlast marks the check byte closing a frame, tuser[0] marks the last byte
// caused by one input item.
// Config port (cfg_*): index 0 = photo length (32 bit), 1 = message id.
// Always ready; write only while the block is idle.
// Path: an accepted item is written into the command queue, then the byte
// emitter registers its first output byte. An item causes 1 output byte as a
// mid-frame photo byte, up to 9 when opening and closing a frame, 13 for a start.
// The byte emitter, one byte per cycle while the receiver is ready, sets the
// rate; the front end runs ahead through a 4-entry command queue.
// Reset clears counters (sequence restarts at 1), empties the queue and
// drops the output valid. A stalled receiver holds the output register; the
// queue fills and then s_axis_tready falls.
module chunked_photo_framer_top #(
  parameter int unsigned Chunk      = cpf_pkg::CHUNK_DEF,
  parameter int unsigned QueueDepth = cpf_pkg::QUEUE_DEPTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] photo_byte
  input  logic [0:0]  s_axis_tuser,   // [0] mode
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [7:0] out_byte
  output logic        m_axis_tlast,   // frame_end
  output logic [0:0]  m_axis_tuser,   // [0] run_last
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic [31:0] cfg_data_i
);
  import cpf_pkg::*;

  logic [31:0] photo_len_q;
  logic [7:0]  msg_id_q;

  logic        fq_valid, fq_ready, bq_valid, bq_pop;
  cmd_t        fq_cmd, bq_cmd;

  // configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      photo_len_q <= '0;
      msg_id_q    <= ID_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (reg_idx_e'(cfg_index_i))
        REG_PHOTO_LEN: photo_len_q <= cfg_data_i;
        REG_MSG_ID:    msg_id_q    <= cfg_data_i[7:0];
        default:       ;
      endcase
    end
  end

  cpf_front #(
    .Chunk (Chunk)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_mode_i   (s_axis_tuser[0]),
    .in_byte_i   (s_axis_tdata),
    .photo_len_i (photo_len_q),
    .msg_id_i    (msg_id_q),
    .cmd_valid_o (fq_valid),
    .cmd_ready_i (fq_ready),
    .cmd_o       (fq_cmd)
  );

  cpf_cmd_fifo #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (fq_valid),
    .wr_ready_o (fq_ready),
    .wr_data_i  (fq_cmd),
    .rd_valid_o (bq_valid),
    .rd_pop_i   (bq_pop),
    .rd_data_o  (bq_cmd)
  );

  cpf_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (bq_valid),
    .cmd_i       (bq_cmd),
    .cmd_pop_o   (bq_pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_byte_o  (m_axis_tdata),
    .frame_end_o (m_axis_tlast),
    .run_last_o  (m_axis_tuser[0])
  );

endmodule

// ----- rtl/cpf_checker.sv -----
// Port-level checks for the photo stream framer, bound to the top level.
module cpf_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata,
  input logic       m_axis_tlast,
  input logic [0:0] m_axis_tuser
);

  // output valid is low on the edge after reset is seen low
  a_reset_quiet: assert property (@(posedge clk_i) !rst_ni |=> !m_axis_tvalid)
    else $error("output valid after reset");

  // a stalled output byte holds
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("stalled output changed");

  // a check byte always ends the run of its input item
  a_end_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tlast |-> m_axis_tuser[0])
    else $error("frame end without run end");

endmodule

bind chunked_photo_framer_top cpf_checker u_cpf_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast),
  .m_axis_tuser  (m_axis_tuser)
);
